[hdl/dst7_pkg.sv]
// ----------------------------------------------------------------------------
// dst7_pkg: shared types and constants of the 3D 7-point diffusion stencil
// Register map, configuration struct, queue item and fixed-point widths.
// ----------------------------------------------------------------------------
`default_nettype none

package dst7_pkg;

  localparam int unsigned DEF_MAX_SIZE_X = 64;
  localparam int unsigned DEF_MAX_SIZE_Y = 64;
  localparam int unsigned DEF_MAX_SIZE_Z = 1024;
  localparam int unsigned DEF_QUEUE_DEPTH = 4;
  localparam int unsigned HALO_PLANES = 1;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned COEFF_W = 18;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned PROD_W = SAMPLE_W + COEFF_W;
  localparam int unsigned TERM_W = PROD_W - FRAC_W;
  localparam int unsigned PSUM_W = TERM_W + 1;
  localparam int unsigned SUM_W = TERM_W + 3;

  localparam int unsigned SIZE_XY_W = 7;
  localparam int unsigned SIZE_Z_W = 11;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  localparam logic [SIZE_XY_W-1:0] RST_SIZE_X = SIZE_XY_W'(64);
  localparam logic [SIZE_XY_W-1:0] RST_SIZE_Y = SIZE_XY_W'(64);
  localparam logic [SIZE_Z_W-1:0] RST_SIZE_Z = SIZE_Z_W'(64);
  localparam logic signed [COEFF_W-1:0] RST_COEFF_CENTER = COEFF_W'(26214);
  localparam logic signed [COEFF_W-1:0] RST_COEFF_AXIS = COEFF_W'(6554);

  typedef enum logic [2:0] {
    REG_SIZE_X       = 3'd0,
    REG_SIZE_Y       = 3'd1,
    REG_SIZE_Z       = 3'd2,
    REG_COEFF_CENTER = 3'd3,
    REG_COEFF_X      = 3'd4,
    REG_COEFF_Y      = 3'd5,
    REG_COEFF_Z      = 3'd6
  } dst7_reg_e;

  typedef struct packed {
    logic [SIZE_XY_W-1:0]        size_x;
    logic [SIZE_XY_W-1:0]        size_y;
    logic [SIZE_Z_W-1:0]         size_z;
    logic signed [COEFF_W-1:0]   coeff_center;
    logic signed [COEFF_W-1:0]   coeff_x;
    logic signed [COEFF_W-1:0]   coeff_y;
    logic signed [COEFF_W-1:0]   coeff_z;
  } dst7_cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] ctr;
    logic signed [SAMPLE_W-1:0] east;
    logic signed [SAMPLE_W-1:0] west;
    logic signed [SAMPLE_W-1:0] north;
    logic signed [SAMPLE_W-1:0] south;
    logic signed [SAMPLE_W-1:0] top;
    logic signed [SAMPLE_W-1:0] bot;
    logic                       last;
  } dst7_item_t;

endpackage

`default_nettype wire

[hdl/dst7_ram.sv]
// ----------------------------------------------------------------------------
// dst7_ram: generic RAM, one write port and two registered read ports
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module dst7_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[hdl/dst7_front.sv]
// ----------------------------------------------------------------------------
// dst7_front: sample intake, raster position and plane store
// Tracks the raster position, writes each sample into the two-plane store,
// reads the center and five stored neighbors and pushes a complete item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dst7_front #(
  parameter int unsigned MAX_SIZE_X  = dst7_pkg::DEF_MAX_SIZE_X,
  parameter int unsigned MAX_SIZE_Y  = dst7_pkg::DEF_MAX_SIZE_Y,
  parameter int unsigned MAX_SIZE_Z  = dst7_pkg::DEF_MAX_SIZE_Z,
  parameter int unsigned QUEUE_DEPTH = dst7_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire dst7_pkg::dst7_cfg_t                  cfg_i,
  input  wire logic                                 restart_i,
  input  wire logic [dst7_pkg::SAMPLE_W-1:0]        sample_i,
  input  wire logic                                 sample_valid_i,
  output logic                                      sample_ready_o,
  input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]     q_count_i,
  output logic                                      push_o,
  output dst7_pkg::dst7_item_t                      push_data_o
);

  import dst7_pkg::*;

  localparam int unsigned XW = (MAX_SIZE_X > 1) ? $clog2(MAX_SIZE_X) : 1;
  localparam int unsigned YW = (MAX_SIZE_Y > 1) ? $clog2(MAX_SIZE_Y) : 1;
  localparam int unsigned XCW = $clog2(MAX_SIZE_X + 1);
  localparam int unsigned YCW = $clog2(MAX_SIZE_Y + 1);
  localparam int unsigned ZCW = $clog2(MAX_SIZE_Z + 1);
  localparam int unsigned ZW = $clog2(MAX_SIZE_Z + 2 * HALO_PLANES);
  localparam int unsigned AW = 1 + YW + XW;
  localparam int unsigned RAM_DEPTH = 2 ** AW;

  logic [XW-1:0]  col_q, col_d;
  logic [YW-1:0]  row_q, row_d;
  logic [ZW-1:0]  plane_q, plane_d;
  logic [XCW-1:0] sx;
  logic [YCW-1:0] sy;
  logic [ZCW-1:0] sz;
  logic           accept;
  logic           col_last;
  logic           row_last;
  logic           plane_last;
  logic           has_result;

  logic                s1_valid_q;
  logic [SAMPLE_W-1:0] s1_top_q;
  logic                s1_east_q;
  logic                s1_west_q;
  logic                s1_north_q;
  logic                s1_south_q;
  logic                s1_last_q;

  logic          slot_cur;
  logic          slot_mid;
  logic [AW-1:0] addr_here;
  logic [AW-1:0] addr_c;
  logic [AW-1:0] addr_e;
  logic [AW-1:0] addr_w;
  logic [AW-1:0] addr_n;
  logic [AW-1:0] addr_s;

  logic [SAMPLE_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b, rd2_a, rd2_b;

  always_comb begin
    if (cfg_i.size_x == '0) begin
      sx = XCW'(1);
    end else if (32'(cfg_i.size_x) > 32'(MAX_SIZE_X)) begin
      sx = XCW'(MAX_SIZE_X);
    end else begin
      sx = XCW'(cfg_i.size_x);
    end
    if (cfg_i.size_y == '0) begin
      sy = YCW'(1);
    end else if (32'(cfg_i.size_y) > 32'(MAX_SIZE_Y)) begin
      sy = YCW'(MAX_SIZE_Y);
    end else begin
      sy = YCW'(cfg_i.size_y);
    end
    if (cfg_i.size_z == '0) begin
      sz = ZCW'(1);
    end else if (32'(cfg_i.size_z) > 32'(MAX_SIZE_Z)) begin
      sz = ZCW'(MAX_SIZE_Z);
    end else begin
      sz = ZCW'(cfg_i.size_z);
    end
  end

  assign sample_ready_o = (32'(q_count_i) + 32'(s1_valid_q)) < 32'(QUEUE_DEPTH);
  assign accept = sample_valid_i && sample_ready_o;

  assign col_last = (32'(col_q) + 32'd1) >= 32'(sx);
  assign row_last = (32'(row_q) + 32'd1) >= 32'(sy);
  assign plane_last = 32'(plane_q) >= (32'(sz) + 2 * HALO_PLANES - 1);
  assign has_result = 32'(plane_q) >= 2 * HALO_PLANES;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    plane_d = plane_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
      plane_d = '0;
    end else if (accept) begin
      if (col_last) begin
        col_d = '0;
        if (row_last) begin
          row_d = '0;
          plane_d = plane_last ? '0 : ZW'(plane_q + 1'b1);
        end else begin
          row_d = YW'(row_q + 1'b1);
        end
      end else begin
        col_d = XW'(col_q + 1'b1);
      end
    end
  end

  assign slot_cur = plane_q[0];
  assign slot_mid = ~plane_q[0];
  assign addr_here = {slot_cur, row_q, col_q};
  assign addr_c = {slot_mid, row_q, col_q};
  assign addr_e = {slot_mid, row_q, XW'(col_q + 1'b1)};
  assign addr_w = {slot_mid, row_q, XW'(col_q - 1'b1)};
  assign addr_n = {slot_mid, YW'(row_q + 1'b1), col_q};
  assign addr_s = {slot_mid, YW'(row_q - 1'b1), col_q};

  dst7_ram #(.WIDTH(SAMPLE_W), .DEPTH(RAM_DEPTH)) u_ram0 (
    .clk_i     (clk_i),
    .we_i      (accept),
    .waddr_i   (addr_here),
    .wdata_i   (sample_i),
    .raddr_a_i (addr_c),
    .raddr_b_i (addr_e),
    .rdata_a_o (rd0_a),
    .rdata_b_o (rd0_b)
  );

  dst7_ram #(.WIDTH(SAMPLE_W), .DEPTH(RAM_DEPTH)) u_ram1 (
    .clk_i     (clk_i),
    .we_i      (accept),
    .waddr_i   (addr_here),
    .wdata_i   (sample_i),
    .raddr_a_i (addr_w),
    .raddr_b_i (addr_n),
    .rdata_a_o (rd1_a),
    .rdata_b_o (rd1_b)
  );

  dst7_ram #(.WIDTH(SAMPLE_W), .DEPTH(RAM_DEPTH)) u_ram2 (
    .clk_i     (clk_i),
    .we_i      (accept),
    .waddr_i   (addr_here),
    .wdata_i   (sample_i),
    .raddr_a_i (addr_s),
    .raddr_b_i (addr_here),
    .rdata_a_o (rd2_a),
    .rdata_b_o (rd2_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      plane_q <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      plane_q <= plane_d;
      s1_valid_q <= accept && has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_top_q <= sample_i;
      s1_east_q <= col_last;
      s1_west_q <= (col_q == '0);
      s1_north_q <= row_last;
      s1_south_q <= (row_q == '0);
      s1_last_q <= (32'(plane_q) >= (32'(sz) + HALO_PLANES)) && row_last && col_last;
    end
  end

  always_comb begin
    push_data_o.ctr = rd0_a;
    push_data_o.east = s1_east_q ? rd0_a : rd0_b;
    push_data_o.west = s1_west_q ? rd0_a : rd1_a;
    push_data_o.north = s1_north_q ? rd0_a : rd1_b;
    push_data_o.south = s1_south_q ? rd0_a : rd2_a;
    push_data_o.top = s1_top_q;
    push_data_o.bot = rd2_b;
    push_data_o.last = s1_last_q;
  end

  assign push_o = s1_valid_q;

  a_s1_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $past(accept))
    else $error("Item pushed without a matching accepted sample.");

  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (32'(q_count_i) < 32'(QUEUE_DEPTH)))
    else $error("Item pushed into a full queue.");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_i |=> (col_q == '0) && (row_q == '0) && (plane_q == '0))
    else $error("Raster position not cleared by a size write.");

endmodule

`default_nettype wire

[hdl/dst7_queue.sv]
// ----------------------------------------------------------------------------
// dst7_queue: short item queue between the front and the back
// Registered storage, read from the head without delay.
// ----------------------------------------------------------------------------
`default_nettype none

module dst7_queue #(
  parameter int unsigned DEPTH = dst7_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire dst7_pkg::dst7_item_t           push_data_i,
  input  wire logic                           pop_i,
  output dst7_pkg::dst7_item_t                pop_data_o,
  output logic                                empty_o,
  output logic [$clog2(DEPTH+1)-1:0]          count_o
);

  import dst7_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  dst7_item_t    mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [CW-1:0] count_q;

  assign pop_data_o = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : PW'(wr_ptr_q + 1'b1);
      end
      if (pop_i) begin
        rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : PW'(rd_ptr_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        count_q <= CW'(count_q + 1'b1);
      end else if (pop_i && !push_i) begin
        count_q <= CW'(count_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (32'(count_q) < DEPTH) || pop_i)
    else $error("Queue overflow.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("Queue underflow.");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("Queue pointers disagree with an empty count.");

endmodule

`default_nettype wire

[hdl/dst7_back.sv]
// ----------------------------------------------------------------------------
// dst7_back: weighted sum of the seven stencil samples
// Seven parallel products, a pairwise add stage and a final add with
// saturation into the output register. The pipeline stalls as one.
// ----------------------------------------------------------------------------
`default_nettype none

module dst7_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire dst7_pkg::dst7_cfg_t             cfg_i,
  input  wire dst7_pkg::dst7_item_t            head_i,
  input  wire logic                            empty_i,
  output logic                                 pop_o,
  output logic [dst7_pkg::SAMPLE_W-1:0]        value_o,
  output logic                                 last_of_grid_o,
  output logic                                 result_valid_o,
  input  wire logic                            result_ready_i
);

  import dst7_pkg::*;

  logic                      en;
  logic signed [PROD_W-1:0]  prod [7];
  logic signed [TERM_W-1:0]  term_q [7];
  logic                      v1_q;
  logic                      last1_q;
  logic signed [PSUM_W-1:0]  psum_d [4];
  logic signed [PSUM_W-1:0]  psum_q [4];
  logic                      v2_q;
  logic                      last2_q;
  logic signed [SUM_W-1:0]   total;
  logic                      pos_ovf;
  logic                      neg_ovf;
  logic [SAMPLE_W-1:0]       sat;
  logic [SAMPLE_W-1:0]       value_q;
  logic                      last_q;
  logic                      out_valid_q;

  assign en = !out_valid_q || result_ready_i;
  assign pop_o = en && !empty_i;

  always_comb begin
    prod[0] = cfg_i.coeff_center * head_i.ctr;
    prod[1] = cfg_i.coeff_x * head_i.east;
    prod[2] = cfg_i.coeff_x * head_i.west;
    prod[3] = cfg_i.coeff_y * head_i.north;
    prod[4] = cfg_i.coeff_y * head_i.south;
    prod[5] = cfg_i.coeff_z * head_i.top;
    prod[6] = cfg_i.coeff_z * head_i.bot;
  end

  always_comb begin
    psum_d[0] = PSUM_W'(term_q[0]) + PSUM_W'(term_q[1]);
    psum_d[1] = PSUM_W'(term_q[2]) + PSUM_W'(term_q[3]);
    psum_d[2] = PSUM_W'(term_q[4]) + PSUM_W'(term_q[5]);
    psum_d[3] = PSUM_W'(term_q[6]);
  end

  always_comb begin
    total = SUM_W'(psum_q[0]) + SUM_W'(psum_q[1]) + SUM_W'(psum_q[2])
          + SUM_W'(psum_q[3]);
    pos_ovf = !total[SUM_W-1] && (|total[SUM_W-2:SAMPLE_W-1]);
    neg_ovf = total[SUM_W-1] && !(&total[SUM_W-2:SAMPLE_W-1]);
    if (pos_ovf) begin
      sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (neg_ovf) begin
      sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat = total[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q <= !empty_i;
      v2_q <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 7; k++) begin
        term_q[k] <= prod[k][PROD_W-1:FRAC_W];
      end
      last1_q <= head_i.last;
      psum_q <= psum_d;
      last2_q <= last1_q;
      value_q <= sat;
      last_q <= last2_q;
    end
  end

  assign value_o = value_q;
  assign last_of_grid_o = last_q;
  assign result_valid_o = out_valid_q;

endmodule

`default_nettype wire

[hdl/diffusion_stencil_3d_7pt_unit.sv]
// ----------------------------------------------------------------------------
// diffusion_stencil_3d_7pt_unit: one explicit step of 3D heat diffusion
// Seven-point stencil over a raster stream of Q16.16 samples with halo
// planes, Q2.16 weights set through an APB register port.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                                   Item
//  sample    in         sample_i, sample_valid_i, sample_ready_o  one sample
//  result    out        value_o, last_of_grid_o, result_valid_o,  one result
//                       result_ready_i
//  config    in/out     psel, penable, pwrite, paddr, pwdata,     register
//                       prdata, pready
//
//  One sample is taken every cycle while sample_ready_o is high; the plane
//  store is three dual-read RAMs holding copies of the two most recent planes,
//  so the center and five neighbors are read in the cycle of acceptance.
//  result_valid_o rises after the front register, the queue and the product,
//  pairwise-sum and output registers. Reset clears the raster position, queue
//  and valid flags and resets the config; the store needs no clearing pass.
//  A stalled output fills the queue (4 entries by default) and drops sample_ready_o.
`default_nettype none

module diffusion_stencil_3d_7pt_unit #(
  parameter int unsigned MAX_SIZE_X  = dst7_pkg::DEF_MAX_SIZE_X,
  parameter int unsigned MAX_SIZE_Y  = dst7_pkg::DEF_MAX_SIZE_Y,
  parameter int unsigned MAX_SIZE_Z  = dst7_pkg::DEF_MAX_SIZE_Z,
  parameter int unsigned QUEUE_DEPTH = dst7_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [dst7_pkg::CFG_AW-1:0]     paddr,
  input  wire logic [dst7_pkg::CFG_DW-1:0]     pwdata,
  output logic      [dst7_pkg::CFG_DW-1:0]     prdata,
  output logic                                 pready,
  input  wire logic [dst7_pkg::SAMPLE_W-1:0]   sample_i,
  input  wire logic                            sample_valid_i,
  output logic                                 sample_ready_o,
  output logic      [dst7_pkg::SAMPLE_W-1:0]   value_o,
  output logic                                 last_of_grid_o,
  output logic                                 result_valid_o,
  input  wire logic                            result_ready_i
);

  import dst7_pkg::*;

  dst7_cfg_t  cfg_q;
  dst7_reg_e  reg_idx;
  logic       cfg_wr;
  logic       restart;
  logic       push;
  dst7_item_t push_data;
  dst7_item_t head;
  logic       empty;
  logic       pop;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  assign pready = 1'b1;
  assign reg_idx = dst7_reg_e'(paddr[4:2]);
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    restart = 1'b0;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_x <= RST_SIZE_X;
      cfg_q.size_y <= RST_SIZE_Y;
      cfg_q.size_z <= RST_SIZE_Z;
      cfg_q.coeff_center <= RST_COEFF_CENTER;
      cfg_q.coeff_x <= RST_COEFF_AXIS;
      cfg_q.coeff_y <= RST_COEFF_AXIS;
      cfg_q.coeff_z <= RST_COEFF_AXIS;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SIZE_X:       cfg_q.size_x <= pwdata[SIZE_XY_W-1:0];
        REG_SIZE_Y:       cfg_q.size_y <= pwdata[SIZE_XY_W-1:0];
        REG_SIZE_Z:       cfg_q.size_z <= pwdata[SIZE_Z_W-1:0];
        REG_COEFF_CENTER: cfg_q.coeff_center <= pwdata[COEFF_W-1:0];
        REG_COEFF_X:      cfg_q.coeff_x <= pwdata[COEFF_W-1:0];
        REG_COEFF_Y:      cfg_q.coeff_y <= pwdata[COEFF_W-1:0];
        REG_COEFF_Z:      cfg_q.coeff_z <= pwdata[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SIZE_X:       prdata = CFG_DW'(cfg_q.size_x);
      REG_SIZE_Y:       prdata = CFG_DW'(cfg_q.size_y);
      REG_SIZE_Z:       prdata = CFG_DW'(cfg_q.size_z);
      REG_COEFF_CENTER: prdata = {{(CFG_DW-COEFF_W){cfg_q.coeff_center[COEFF_W-1]}},
                                  cfg_q.coeff_center};
      REG_COEFF_X:      prdata = {{(CFG_DW-COEFF_W){cfg_q.coeff_x[COEFF_W-1]}},
                                  cfg_q.coeff_x};
      REG_COEFF_Y:      prdata = {{(CFG_DW-COEFF_W){cfg_q.coeff_y[COEFF_W-1]}},
                                  cfg_q.coeff_y};
      REG_COEFF_Z:      prdata = {{(CFG_DW-COEFF_W){cfg_q.coeff_z[COEFF_W-1]}},
                                  cfg_q.coeff_z};
      default:          prdata = '0;
    endcase
  end

  dst7_front #(
    .MAX_SIZE_X  (MAX_SIZE_X),
    .MAX_SIZE_Y  (MAX_SIZE_Y),
    .MAX_SIZE_Z  (MAX_SIZE_Z),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .restart_i      (restart),
    .sample_i       (sample_i),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .q_count_i      (q_count),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  dst7_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (head),
    .empty_o     (empty),
    .count_o     (q_count)
  );

  dst7_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .head_i         (head),
    .empty_i        (empty),
    .pop_o          (pop),
    .value_o        (value_o),
    .last_of_grid_o (last_of_grid_o),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i)
  );

endmodule

`default_nettype wire
